### rtl/pfb_pkg.sv
// ----------------------------------------------------------------------------
// pfb_pkg
// Types, codes and the raster combine function of the page framebuffer blit.
// ----------------------------------------------------------------------------
`default_nettype none

package pfb_pkg;

    // raster operation codes
    localparam logic [2:0] ROP_OR      = 3'd0;
    localparam logic [2:0] ROP_XOR     = 3'd1;
    localparam logic [2:0] ROP_INV_OR  = 3'd2;
    localparam logic [2:0] ROP_INV_XOR = 3'd3;
    localparam logic [2:0] ROP_REPLACE = 3'd4;

    // request function codes
    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // register word offsets (paddr[2])
    localparam logic REG_RASTER_OP = 1'b0;

    typedef struct packed {
        logic       func;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] pixels;
    } blit_in_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       clipped;
    } blit_out_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LO,
        ST_HI,
        ST_HOLD
    } state_t;

    function automatic logic [7:0] apply_op(
        input logic [2:0] op,
        input logic [7:0] old,
        input logic [7:0] pat,
        input logic [7:0] inv_pat,
        input logic [7:0] keep
    );
        logic [7:0] r;
        case (op)
            ROP_OR:      r = old | pat;
            ROP_XOR:     r = old ^ pat;
            ROP_INV_OR:  r = old | inv_pat;
            ROP_INV_XOR: r = old ^ inv_pat;
            ROP_REPLACE: r = (old & keep) | pat;
            default:     r = old;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/page_framebuffer_byte_blit.sv
// ----------------------------------------------------------------------------
// page_framebuffer_byte_blit
// Page-organized monochrome framebuffer with vertical byte put and read.
// ----------------------------------------------------------------------------
// The frame store is one single-port-write RAM addressed {page, column}; a put
// is a read-modify-write of one or two page bytes through that RAM: the lo byte
// is read, then written back while the hi byte is read if the put is split over
// two pages, then the hi byte is written. A read returns the byte from the RAM's
// read register, and a clipped request is answered without touching the RAM.
// After reset the block sweeps the RAM to zero, one byte a cycle, before s_ready
// rises; register writes are taken during that time. A finished result sits in
// an output register, so the next request is taken while it waits for m_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module page_framebuffer_byte_blit #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // request channel
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire pfb_pkg::blit_in_t    s_data,
    // result channel
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output pfb_pkg::blit_out_t        m_data,
    // register port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready
);

    localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int AW    = CW + PW;
    localparam int DEPTH = 2 ** AW;
    localparam int ROWS  = PAGES * 8;

    // register port
    logic [2:0] raster_op_reg;
    logic       reg_write;

    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raster_op_reg <= pfb_pkg::ROP_REPLACE;
        end else if (reg_write && paddr[2] == pfb_pkg::REG_RASTER_OP) begin
            raster_op_reg <= pwdata[2:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == pfb_pkg::REG_RASTER_OP) begin
            prdata = {29'd0, raster_op_reg};
        end
    end

    // request capture
    pfb_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   clr_reg;
    logic            func_reg;
    logic [CW-1:0]   col_reg;
    logic [PW-1:0]   page_reg;
    logic [2:0]      shift_reg;
    logic [7:0]      pix_reg;
    logic            two_reg;
    pfb_pkg::blit_out_t res_reg;

    logic            in_clip;
    logic [CW-1:0]   in_col;
    logic [PW-1:0]   in_page;
    logic            in_two;
    logic            capture;

    assign in_col  = s_data.col[CW-1:0];
    assign in_page = s_data.row[3 +: PW];
    assign in_clip = (int'(s_data.col) >= COLUMNS) || (int'(s_data.row) >= ROWS);
    // second page only when shifted and there is a page below
    assign in_two  = (s_data.row[2:0] != 3'd0) && (int'(in_page) + 1 < PAGES);

    always_ff @(posedge aclk) begin
        if (capture) begin
            func_reg  <= s_data.func;
            col_reg   <= in_col;
            page_reg  <= in_page;
            shift_reg <= s_data.row[2:0];
            pix_reg   <= s_data.pixels;
            two_reg   <= in_two;
        end
    end

    // shifted patterns for the upper (lo) and lower (hi) page bytes
    logic [15:0] pat_w, ipat_w, mask_w;
    logic [AW-1:0] addr_lo, addr_hi;

    assign pat_w   = {8'd0, pix_reg} << shift_reg;
    assign ipat_w  = {8'd0, ~pix_reg} << shift_reg;
    assign mask_w  = 16'h00FF << shift_reg;
    assign addr_lo = {page_reg, col_reg};
    assign addr_hi = {page_reg + PW'(1), col_reg};

    // frame store
    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [7:0]      ram_wdata, ram_rdata;

    pfb_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer; a write and the next read of the same byte never share a cycle
    logic               out_free;
    logic               res_valid;
    pfb_pkg::blit_out_t res_data;
    logic               out_load;
    pfb_pkg::blit_out_t out_data;

    assign out_free = !m_valid || m_ready;

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        capture    = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = addr_lo;
        ram_wdata  = 8'd0;
        ram_re     = 1'b0;
        ram_raddr  = {in_page, in_col};
        res_valid  = 1'b0;
        res_data   = '0;
        out_load   = 1'b0;
        out_data   = res_reg;
        case (state_reg)
            pfb_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                if (clr_reg == '1) begin
                    state_next = pfb_pkg::ST_IDLE;
                end
            end
            pfb_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    capture = 1'b1;
                    if (in_clip) begin
                        res_valid        = 1'b1;
                        res_data.clipped = 1'b1;
                    end else begin
                        ram_re     = 1'b1;
                        state_next = pfb_pkg::ST_LO;
                    end
                end
            end
            pfb_pkg::ST_LO: begin
                if (func_reg == pfb_pkg::FUNC_READ) begin
                    res_valid          = 1'b1;
                    res_data.read_byte = ram_rdata;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = addr_lo;
                    ram_wdata = pfb_pkg::apply_op(raster_op_reg, ram_rdata, pat_w[7:0],
                                                  ipat_w[7:0], ~mask_w[7:0]);
                    if (two_reg) begin
                        ram_re     = 1'b1;
                        ram_raddr  = addr_hi;
                        state_next = pfb_pkg::ST_HI;
                    end else begin
                        res_valid = 1'b1;
                    end
                end
            end
            pfb_pkg::ST_HI: begin
                ram_we    = 1'b1;
                ram_waddr = addr_hi;
                ram_wdata = pfb_pkg::apply_op(raster_op_reg, ram_rdata, pat_w[15:8],
                                              ipat_w[15:8], mask_w[7:0]);
                res_valid = 1'b1;
            end
            pfb_pkg::ST_HOLD: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = pfb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pfb_pkg::ST_IDLE;
            end
        endcase
        if (res_valid) begin
            out_data = res_data;
            if (out_free) begin
                out_load   = 1'b1;
                state_next = pfb_pkg::ST_IDLE;
            end else begin
                state_next = pfb_pkg::ST_HOLD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pfb_pkg::ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == pfb_pkg::ST_CLEAR) begin
                clr_reg <= clr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res_data;
        end
    end

    // output register
    logic               m_valid_reg;
    pfb_pkg::blit_out_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= out_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

### rtl/pfb_ram.sv
// ----------------------------------------------------------------------------
// pfb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/pfb_checker.sv
// ----------------------------------------------------------------------------
// pfb_checker
// Port-level checks of the page framebuffer blit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pfb_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire pfb_pkg::blit_out_t m_data,
    input wire logic               psel,
    input wire logic               penable,
    input wire logic               pwrite,
    input wire logic [2:0]         paddr,
    input wire logic [31:0]        pwdata,
    input wire logic [31:0]        prdata
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // a clipped request never carries data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.clipped |-> m_data.read_byte == 8'd0)
        else $error("clipped result with nonzero byte");

    // the clearing sweep keeps requests out right after reset
    assert property (@(posedge aclk)
        aresetn && !$past(aresetn) |-> !s_ready && !m_valid)
        else $error("request taken during clearing sweep");

    // register read back shows the last value written
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(psel && penable && pwrite && paddr[2] == pfb_pkg::REG_RASTER_OP)
        && paddr[2] == pfb_pkg::REG_RASTER_OP
        |-> prdata[2:0] == $past(pwdata[2:0]))
        else $error("raster op read back mismatch");

endmodule

bind page_framebuffer_byte_blit pfb_checker u_pfb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata)
);

`default_nettype wire

### tb/sv/page_framebuffer_byte_blit_checker.sv
// ----------------------------------------------------------------------------
// page_framebuffer_byte_blit_checker
// Watches the request, result and register ports of the page framebuffer
// blit, keeps its own copy of the frame store and raster op, predicts the
// result of every accepted request and compares it with the results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_framebuffer_byte_blit_checker #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire pfb_pkg::blit_in_t    s_data,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire pfb_pkg::blit_out_t   m_data,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic                 pready,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output int                        mismatch_count,
    output int                        results_owed
);

    logic [7:0]         frame_bytes [COLUMNS*PAGES];
    logic [2:0]         raster_op;
    pfb_pkg::blit_out_t results_due [$];
    pfb_pkg::blit_out_t want;
    int                 mismatches = 0;

    function automatic logic [7:0] rop_merge(
        input logic [7:0] old,
        input logic [7:0] pat,
        input logic [7:0] inv_pat,
        input logic [7:0] keep
    );
        case (raster_op)
            pfb_pkg::ROP_OR:      return old | pat;
            pfb_pkg::ROP_XOR:     return old ^ pat;
            pfb_pkg::ROP_INV_OR:  return old | inv_pat;
            pfb_pkg::ROP_INV_XOR: return old ^ inv_pat;
            pfb_pkg::ROP_REPLACE: return (old & keep) | pat;
            default:              return old;
        endcase
    endfunction

    // updates the store for a put, returns what the block should answer
    function automatic pfb_pkg::blit_out_t blit_predict(input pfb_pkg::blit_in_t req);
        pfb_pkg::blit_out_t res;
        logic [2:0]         shift;
        logic [7:0]         inv;
        int                 page;
        int                 addr;
        res = '0;
        if (req.col >= COLUMNS || req.row >= 8 * PAGES) begin
            res.clipped = 1'b1;
            return res;
        end
        shift = req.row[2:0];
        page  = int'(req.row) / 8;
        addr  = page * COLUMNS + int'(req.col);
        if (req.func == pfb_pkg::FUNC_READ) begin
            res.read_byte = frame_bytes[addr];
            return res;
        end
        inv = ~req.pixels;
        // rows above the shifted byte are kept in replace mode
        frame_bytes[addr] = rop_merge(frame_bytes[addr], req.pixels << shift,
                                      inv << shift, 8'hFF >> (4'd8 - shift));
        if (shift != 3'd0 && page + 1 < PAGES) begin
            frame_bytes[addr + COLUMNS] = rop_merge(frame_bytes[addr + COLUMNS],
                                                    req.pixels >> (4'd8 - shift),
                                                    inv >> (4'd8 - shift),
                                                    8'hFF << shift);
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
            raster_op = pfb_pkg::ROP_REPLACE;
            results_due.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == pfb_pkg::REG_RASTER_OP)
                raster_op = pwdata[2:0];
            if (s_valid && s_ready)
                results_due.push_back(blit_predict(s_data));
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $error("result with no request outstanding: read_byte %02h clipped %0b",
                           m_data.read_byte, m_data.clipped);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (m_data.read_byte !== want.read_byte) begin
                        $error("read_byte mismatch: expected %02h, got %02h",
                               want.read_byte, m_data.read_byte);
                        mismatches++;
                    end
                    if (m_data.clipped !== want.clipped) begin
                        $error("clipped mismatch: expected %0b, got %0b",
                               want.clipped, m_data.clipped);
                        mismatches++;
                    end
                end
            end
        end
        results_owed   <= results_due.size();
        mismatch_count <= mismatches;
    end

endmodule

### tb/sv/page_framebuffer_byte_blit_test.sv
// ----------------------------------------------------------------------------
// page_framebuffer_byte_blit_test
// Drives puts and reads into the page framebuffer blit under every raster op,
// with random gaps on both channels and one long result stall, and leaves
// prediction and comparison to the checker instantiated beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_framebuffer_byte_blit_test;

    localparam int         LIMIT       = 200000;
    localparam int         PHASE_ITEMS = 170;
    // codes past replace leave the store alone
    localparam logic [2:0] ROP_NOP_5   = 3'd5;
    localparam logic [2:0] ROP_NOP_6   = 3'd6;
    localparam logic [2:0] ROP_NOP_7   = 3'd7;
    localparam logic [2:0] ADDR_RASTER_OP = {pfb_pkg::REG_RASTER_OP, 2'b00};

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    pfb_pkg::blit_in_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    pfb_pkg::blit_out_t m_data;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [2:0]         paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    int mismatch_count;
    int results_owed;
    int cycles = 0;
    bit steady = 1'b0;
    bit hold_request = 1'b0;

    page_framebuffer_byte_blit dut (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_data,
        .m_valid, .m_ready, .m_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    page_framebuffer_byte_blit_checker checker_i (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_data,
        .m_valid, .m_ready, .m_data,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .mismatch_count, .results_owed
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // result side: random stalls, one long hold-off to back the block up
    initial begin : result_sink
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_done) begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 8);
            end
        end
    end

    task automatic write_raster_op(input logic [2:0] op);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_RASTER_OP;
        pwdata  <= {29'd0, op};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic offer_request(input pfb_pkg::blit_in_t req);
        if (!steady && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic offer_fields(input logic func, input logic [7:0] col,
                                input logic [7:0] row, input logic [7:0] pixels);
        pfb_pkg::blit_in_t req;
        req.func   = func;
        req.col    = col;
        req.row    = row;
        req.pixels = pixels;
        offer_request(req);
    endtask

    // block is idle once every result is back and the pipe has emptied
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic pfb_pkg::blit_in_t random_request();
        pfb_pkg::blit_in_t req;
        req.func   = ($urandom_range(99) < 40) ? pfb_pkg::FUNC_READ : pfb_pkg::FUNC_PUT;
        req.pixels = 8'($urandom_range(255));
        case ($urandom_range(9))
            0: begin
                req.col = 8'($urandom_range(255));
                req.row = 8'($urandom_range(255));
            end
            1, 2, 3: begin
                req.col = 8'($urandom_range(127));
                req.row = 8'($urandom_range(63));
            end
            default: begin
                // a few columns at both edges so reads see earlier puts
                req.col = $urandom_range(1) ? 8'($urandom_range(3))
                                            : 8'(124 + $urandom_range(3));
                req.row = 8'($urandom_range(63));
            end
        endcase
        return req;
    endfunction

    initial begin : stimulus
        logic [2:0] probe_ops [6];
        logic [2:0] phase_ops [10];
        probe_ops = '{pfb_pkg::ROP_OR, pfb_pkg::ROP_XOR, pfb_pkg::ROP_INV_OR,
                      pfb_pkg::ROP_INV_XOR, ROP_NOP_5, ROP_NOP_7};
        phase_ops = '{pfb_pkg::ROP_OR, pfb_pkg::ROP_XOR, pfb_pkg::ROP_INV_OR,
                      pfb_pkg::ROP_INV_XOR, pfb_pkg::ROP_REPLACE,
                      ROP_NOP_5, ROP_NOP_6, ROP_NOP_7, pfb_pkg::ROP_XOR,
                      pfb_pkg::ROP_REPLACE};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_raster_op(pfb_pkg::ROP_REPLACE);

        // replace mode: aligned, split, bottom page and clipped requests
        offer_fields(pfb_pkg::FUNC_PUT,  8'd0,   8'd0,   8'hFF);
        offer_fields(pfb_pkg::FUNC_READ, 8'd0,   8'd0,   8'h00);
        offer_fields(pfb_pkg::FUNC_PUT,  8'd0,   8'd3,   8'h00);
        offer_fields(pfb_pkg::FUNC_READ, 8'd0,   8'd7,   8'h00);
        offer_fields(pfb_pkg::FUNC_PUT,  8'd127, 8'd63,  8'hA5);
        offer_fields(pfb_pkg::FUNC_READ, 8'd127, 8'd56,  8'h00);
        offer_fields(pfb_pkg::FUNC_PUT,  8'd5,   8'd13,  8'h81);
        offer_fields(pfb_pkg::FUNC_READ, 8'd5,   8'd8,   8'h00);
        offer_fields(pfb_pkg::FUNC_READ, 8'd5,   8'd16,  8'h00);
        offer_fields(pfb_pkg::FUNC_PUT,  8'd128, 8'd0,   8'hFF);
        offer_fields(pfb_pkg::FUNC_PUT,  8'd0,   8'd64,  8'hFF);
        offer_fields(pfb_pkg::FUNC_READ, 8'd255, 8'd255, 8'h00);
        offer_fields(pfb_pkg::FUNC_PUT,  8'd255, 8'd255, 8'hFF);
        offer_fields(pfb_pkg::FUNC_READ, 8'd0,   8'd63,  8'hFF);
        drain_results();

        // one split put and a read-back under each combining op and nop codes 5 and 7
        foreach (probe_ops[i]) begin
            write_raster_op(probe_ops[i]);
            offer_fields(pfb_pkg::FUNC_PUT,  8'd5, 8'd13, 8'h3C);
            offer_fields(pfb_pkg::FUNC_READ, 8'd5, 8'd8,  8'h00);
            drain_results();
        end

        foreach (phase_ops[p]) begin
            write_raster_op(phase_ops[p]);
            if (p == 2) hold_request = 1'b1;
            steady = (p == 6);
            repeat (PHASE_ITEMS) offer_request(random_request());
            drain_results();
        end
        steady = 1'b0;

        if (mismatch_count == 0 && results_owed == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
